// ----- src/controller_packet_receiver_assert.svh -----
// assertion macros for the controller packet receiver
`ifndef CONTROLLER_PACKET_RECEIVER_ASSERT_SVH
`define CONTROLLER_PACKET_RECEIVER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cpr_pkg.sv -----
// types and constants of the controller packet receiver
`timescale 1ns / 1ps

package cpr_pkg;

    localparam logic       OP_BYTE       = 1'b0;
    localparam logic       OP_TICK       = 1'b1;

    localparam logic [7:0] START_BYTE    = 8'h21;
    localparam logic [7:0] TYPE_BUTTON   = 8'h42;
    localparam logic [7:0] TYPE_COLOR    = 8'h43;
    localparam logic [7:0] DIGIT_ZERO    = 8'h30;
    localparam logic [4:0] LEN_BUTTON    = 5'd5;
    localparam logic [4:0] LEN_COLOR     = 5'd6;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_COLOR  = 2'd1,
        KIND_BUTTON = 2'd2
    } kind_t;

    typedef struct packed {
        logic       timed_out;
        logic [7:0] button_bits;
        logic [7:0] color_blue;
        logic [7:0] color_green;
        logic [7:0] color_red;
        kind_t      packet_kind;
        logic       packet_done;
    } result_t;

endpackage

// ----- src/cpr_core.sv -----
// packet state and per-item update logic
`timescale 1ns / 1ps

module cpr_core
    import cpr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        step_en,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    output result_t     result
);

    localparam logic [4:0] DEPTH_C = 5'(BUFFER_DEPTH);

    logic [15:0] timeout_reg;
    logic [4:0]  count_reg, count_next;
    logic [15:0] idle_reg, idle_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  blue_reg, blue_next;
    logic [7:0]  button_reg, button_next;
    logic [7:0]  packet_bytes_reg [4];

    logic [4:0]  pos;
    logic [4:0]  count_inc;
    logic [15:0] idle_inc;
    logic [7:0]  btn_num;
    logic        btn_ok;
    logic [2:0]  btn_idx;
    logic [7:0]  btn_mask;
    logic        pb_we;
    logic [1:0]  pb_idx;

    // start byte restarts the packet at position zero
    assign pos       = (rx_byte == START_BYTE) ? 5'd0 : count_reg;
    assign count_inc = pos + 5'd1;
    assign pb_idx    = 2'(pos - 5'd1);
    assign idle_inc  = (idle_reg != 16'hFFFF) ? idle_reg + 16'd1 : idle_reg;
    assign btn_num   = packet_bytes_reg[1] - DIGIT_ZERO;
    assign btn_ok    = (btn_num >= 8'd1) && (btn_num <= 8'd8);
    assign btn_idx   = 3'(btn_num - 8'd1);
    assign btn_mask  = 8'(1) << btn_idx;

    always_comb begin
        count_next  = count_reg;
        idle_next   = idle_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        blue_next   = blue_reg;
        button_next = button_reg;
        pb_we       = 1'b0;
        result.packet_done = 1'b0;
        result.packet_kind = KIND_NONE;
        result.timed_out   = 1'b0;
        if (step_en) begin
            if (op == OP_TICK) begin
                idle_next = idle_inc;
                if ((idle_inc > timeout_reg) && (count_reg != 5'd0)) begin
                    count_next       = 5'd0;
                    result.timed_out = 1'b1;
                end
            end else begin
                idle_next = 16'd0;
                if (count_reg >= DEPTH_C) begin
                    count_next = 5'd0;
                end else begin
                    pb_we      = (pos >= 5'd1) && (pos <= 5'd4);
                    count_next = count_inc;
                    // completion lengths only occur after position 1 was written
                    if ((packet_bytes_reg[0] == TYPE_BUTTON) && (count_inc == LEN_BUTTON)) begin
                        result.packet_done = 1'b1;
                        result.packet_kind = KIND_BUTTON;
                        count_next         = 5'd0;
                        if (btn_ok) begin
                            if (packet_bytes_reg[2] != DIGIT_ZERO) begin
                                button_next = button_reg | btn_mask;
                            end else begin
                                button_next = button_reg & ~btn_mask;
                            end
                        end
                    end else if ((packet_bytes_reg[0] == TYPE_COLOR)
                                 && (count_inc == LEN_COLOR)) begin
                        result.packet_done = 1'b1;
                        result.packet_kind = KIND_COLOR;
                        count_next         = 5'd0;
                        red_next           = packet_bytes_reg[1];
                        green_next         = packet_bytes_reg[2];
                        blue_next          = packet_bytes_reg[3];
                    end
                end
            end
        end
        result.color_red   = red_next;
        result.color_green = green_next;
        result.color_blue  = blue_next;
        result.button_bits = button_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            count_reg   <= 5'd0;
            idle_reg    <= 16'd0;
            red_reg     <= 8'd0;
            green_reg   <= 8'd0;
            blue_reg    <= 8'd0;
            button_reg  <= 8'd0;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            count_reg  <= count_next;
            idle_reg   <= idle_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            button_reg <= button_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pb_we) begin
            packet_bytes_reg[pb_idx] <= rx_byte;
        end
    end

endmodule

// ----- src/controller_packet_receiver.sv -----
// flow: an accepted request is held in the input register, then moves to the result
// register when it advances, and its result is taken from the result register
// throughput: one request per cycle while m_axis_tready is high; a stalled result
// holds one more request in the input register, then s_axis_tready drops
// reset: synchronous active-low aresetn clears both stage valids, the packet
// state and the held colors and buttons, and sets the timeout to 500
`timescale 1ns / 1ps

`include "controller_packet_receiver_assert.svh"

module controller_packet_receiver
    import cpr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] color_red, [15:8] color_green, [23:16] color_blue, [31:24] button_bits
    output logic [31:0] m_axis_tdata,
    // [0] packet_done, [2:1] packet_kind, [3] timed_out
    output logic [3:0]  m_axis_tuser
);

    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    result;
    logic       advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    cpr_core #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .step_en  (advance),
        .op       (in_op_reg),
        .rx_byte  (in_byte_reg),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_op_reg   <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.button_bits, out_reg.color_blue,
                            out_reg.color_green, out_reg.color_red};
    assign m_axis_tuser  = {out_reg.timed_out, out_reg.packet_kind, out_reg.packet_done};

    `CPR_ASSERT_NOW(a_kind_matches_done, aclk, aresetn, m_axis_tvalid,
        out_reg.packet_done == (out_reg.packet_kind != KIND_NONE),
        "packet kind disagrees with packet done")
    `CPR_ASSERT_NOW(a_timeout_not_done, aclk, aresetn, m_axis_tvalid && out_reg.timed_out,
        !out_reg.packet_done, "timeout reported together with a completed packet")
    `CPR_ASSERT_NEXT(a_advance_fills_output, aclk, aresetn, advance,
        out_valid_reg, "result register not loaded after a request advanced")
    `CPR_ASSERT_NOW(a_tick_never_done, aclk, aresetn, advance && (in_op_reg == OP_TICK),
        !result.packet_done, "tick request completed a packet")

endmodule
